// ----- rtl/srt_pkg.sv -----
`timescale 1ns / 1ps
// srt_pkg: shared constants, types and the crc function of the shader record table
// used by srt_ctrl, srt_dp and shader_record_table; depends on nothing

package srt_pkg;

	localparam int TABLE_ENTRIES = 32768;
	localparam int TOKEN_CAP     = 65536;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int EC_W          = $clog2(TABLE_ENTRIES + 2);
	localparam int CNT_W         = $clog2(TOKEN_CAP + 1);
	localparam int HANDLE_W      = 48;
	localparam int LEN_W         = 19;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [31:0] END_WORD = 32'h0000_FFFF;

	typedef enum logic [2:0] {
		ST_RECORDED   = 3'd0,
		ST_NO_END     = 3'd1,
		ST_FULL_FIRST = 3'd2,
		ST_FULL_AGAIN = 3'd3,
		ST_BOUND      = 3'd4,
		ST_UNMATCHED  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_COLLECT = 2'd1,
		PH_DISCARD = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'd0,
		FSM_RD   = 2'd1,
		FSM_CMP  = 2'd2
	} fsm_t;

	typedef struct packed {
		logic [31:0]         crc;
		logic [LEN_W-1:0]    length;
		logic                kind;
		logic [HANDLE_W-1:0] handle;
	} rec_t;

	typedef struct packed {
		logic        used;
		logic [31:0] binds;
	} bind_t;

	typedef struct packed {
		logic busy;
		logic walk_init;
		logic rec_rd;
		logic walk_next;
		logic bind_wr;
		logic res_unmatched;
	} srt_cmd_t;

	typedef struct packed {
		logic bind_go;
		logic walk_end;
		logic hit;
	} srt_sts_t;

	// reflected crc over one word, low byte first
	function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] word);
		logic [31:0] c;
		c = crc ^ word;
		for (int k = 0; k < 32; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- rtl/srt_ram.sv -----
`timescale 1ns / 1ps
// srt_ram: generic single write port, single read port ram with registered read
// depends on nothing

module srt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/srt_ctrl.sv -----
`timescale 1ns / 1ps
// srt_ctrl: state machine that sequences the bind search over the record table
// depends on srt_pkg

module srt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  srt_pkg::srt_sts_t sts,
	output srt_pkg::srt_cmd_t cmd
);
	import srt_pkg::*;

	fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			FSM_IDLE: begin
				if (sts.bind_go) begin
					cmd.walk_init = 1'b1;
					state_d       = FSM_RD;
				end
			end
			FSM_RD: begin
				cmd.busy = 1'b1;
				if (sts.walk_end) begin
					cmd.res_unmatched = 1'b1;
					state_d           = FSM_IDLE;
				end else begin
					cmd.rec_rd = 1'b1;
					state_d    = FSM_CMP;
				end
			end
			FSM_CMP: begin
				cmd.busy = 1'b1;
				if (sts.hit) begin
					cmd.bind_wr = 1'b1;
					state_d     = FSM_IDLE;
				end else begin
					cmd.walk_next = 1'b1;
					state_d       = FSM_RD;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/srt_dp.sv -----
`timescale 1ns / 1ps
// srt_dp: crc and token counting, record and bind memories, walk index, output register
// depends on srt_pkg and srt_ram

module srt_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         opcode,
	input  logic [srt_pkg::HANDLE_W-1:0] handle,
	input  logic                         is_pixel,
	input  logic [31:0]                  token,
	input  logic                         stream_start,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [2:0]                   status,
	input  srt_pkg::srt_cmd_t            cmd,
	output srt_pkg::srt_sts_t            sts
);
	import srt_pkg::*;

	logic [EC_W-1:0]     entry_count_q;
	logic [15:0]         used_count_q;
	logic [31:0]         running_crc_q;
	logic [CNT_W-1:0]    token_counter_q;
	phase_t              phase_q;
	logic [HANDLE_W-1:0] pending_handle_q;
	logic                pending_kind_q;
	logic [HANDLE_W-1:0] key_handle_q;
	logic                key_kind_q;
	logic [EC_W-1:0]     walk_q;
	logic                out_valid_q;
	status_t             status_q;

	logic                acc, cre, proc;
	logic [31:0]         crc_in, crc_new;
	logic [CNT_W-1:0]    cnt_new;
	logic                is_end, at_cap, do_ins, full;
	logic [EC_W-1:0]     limit;
	rec_t                rec_w, rec_r;
	bind_t               bind_w, bind_r;
	logic                rec_we, bind_we;
	logic [IDX_W-1:0]    bind_waddr;
	logic                load_out;
	status_t             load_status;
	logic [CNT_W+1:0]    bytes;

	assign in_stall = cmd.busy || (out_valid_q && out_stall);
	assign acc      = in_valid && !in_stall;
	assign cre      = acc && !opcode;
	assign proc     = cre && (stream_start || phase_q == PH_COLLECT);

	assign crc_in  = stream_start ? ALL_ONES : running_crc_q;
	assign crc_new = crc_word(crc_in, token);
	assign cnt_new = (stream_start ? '0 : token_counter_q) + 1'b1;
	assign is_end  = token == END_WORD;
	assign at_cap  = cnt_new >= CNT_W'(TOKEN_CAP);
	assign do_ins  = proc && (is_end || at_cap);
	assign full    = entry_count_q >= EC_W'(TABLE_ENTRIES);
	assign bytes   = {cnt_new, 2'b00};

	assign rec_w.handle = stream_start ? handle : pending_handle_q;
	assign rec_w.kind   = stream_start ? is_pixel : pending_kind_q;
	assign rec_w.crc    = is_end ? (crc_new ^ ALL_ONES) : 32'd0;
	assign rec_w.length = is_end ? bytes[LEN_W-1:0] : '0;
	assign rec_we       = do_ins && !full;

	assign limit        = full ? EC_W'(TABLE_ENTRIES) : entry_count_q;
	assign sts.bind_go  = acc && opcode && (handle != '0);
	assign sts.walk_end = walk_q >= limit;
	assign sts.hit      = (rec_r.handle == key_handle_q) && (rec_r.kind == key_kind_q);

	// one write port serves record inserts and bind updates
	assign bind_we    = rec_we || cmd.bind_wr;
	assign bind_waddr = cmd.bind_wr ? walk_q[IDX_W-1:0] : entry_count_q[IDX_W-1:0];
	always_comb begin
		bind_w = '0;
		if (cmd.bind_wr) begin
			bind_w.used  = 1'b1;
			bind_w.binds = (bind_r.binds == ALL_ONES) ? bind_r.binds : bind_r.binds + 32'd1;
		end
	end

	srt_ram #(.WIDTH($bits(rec_t)), .DEPTH(TABLE_ENTRIES)) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (entry_count_q[IDX_W-1:0]),
		.wdata (rec_w),
		.re    (cmd.rec_rd),
		.raddr (walk_q[IDX_W-1:0]),
		.rdata (rec_r)
	);

	srt_ram #(.WIDTH($bits(bind_t)), .DEPTH(TABLE_ENTRIES)) u_bind_ram (
		.clk   (clk),
		.we    (bind_we),
		.waddr (bind_waddr),
		.wdata (bind_w),
		.re    (cmd.rec_rd),
		.raddr (walk_q[IDX_W-1:0]),
		.rdata (bind_r)
	);

	always_comb begin
		load_out    = 1'b0;
		load_status = ST_RECORDED;
		if (do_ins) begin
			load_out = 1'b1;
			if (full) begin
				load_status = (entry_count_q == EC_W'(TABLE_ENTRIES)) ? ST_FULL_FIRST
				                                                       : ST_FULL_AGAIN;
			end else begin
				load_status = is_end ? ST_RECORDED : ST_NO_END;
			end
		end else if (cmd.res_unmatched) begin
			load_out    = 1'b1;
			load_status = ST_UNMATCHED;
		end else if (cmd.bind_wr) begin
			load_out    = 1'b1;
			load_status = ST_BOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q    <= '0;
			used_count_q     <= '0;
			running_crc_q    <= ALL_ONES;
			token_counter_q  <= '0;
			phase_q          <= PH_IDLE;
			pending_handle_q <= '0;
			pending_kind_q   <= 1'b0;
			walk_q           <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cre && stream_start) begin
				pending_handle_q <= handle;
				pending_kind_q   <= is_pixel;
			end
			if (proc) begin
				running_crc_q   <= crc_new;
				token_counter_q <= cnt_new;
				if (is_end) begin
					phase_q <= PH_IDLE;
				end else if (at_cap) begin
					phase_q <= PH_DISCARD;
				end else begin
					phase_q <= PH_COLLECT;
				end
			end
			// counts once past the table size to mark the first overflow
			if (do_ins && entry_count_q <= EC_W'(TABLE_ENTRIES)) begin
				entry_count_q <= entry_count_q + 1'b1;
			end
			if (cmd.bind_wr && !bind_r.used) begin
				used_count_q <= used_count_q + 16'd1;
			end
			if (cmd.walk_init) begin
				walk_q <= '0;
			end else if (cmd.walk_next) begin
				walk_q <= walk_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cre && stream_start || cmd.walk_init) begin
			key_handle_q <= handle;
			key_kind_q   <= is_pixel;
		end
		if (load_out) begin
			status_q <= load_status;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= EC_W'(TABLE_ENTRIES + 1))
		else $error("entry count beyond one past the table");
	a_bind_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.bind_wr |-> sts.hit && !sts.walk_end)
		else $error("bind update without a matching record");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !(out_valid_q && out_stall))
		else $error("result loaded over a stalled result");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rec_rd |-> walk_q < limit)
		else $error("search read past the written records");

endmodule

// ----- rtl/shader_record_table.sv -----
`timescale 1ns / 1ps
// shader_record_table: top level, joins the search controller and the datapath
// depends on srt_pkg, srt_ctrl and srt_dp

// Creation token words (opcode 0) get a whole-word crc step and the token counter update
// in the cycle they are accepted, with the record written into the table memory, while
// it is not full, at the end word or at the token cap. A bind (opcode 1) with a nonzero
// handle walks the written records from the first, with a read state and then a
// compare state per record; it stops at the first match or reports no match after all
// min(records, TABLE_ENTRIES); the input stalls meanwhile. Results sit in an output
// register; while it is stalled the input is stalled too. The tables need no clearing
// after reset: the entry count bounds every search.
module shader_record_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [47:0] handle,
	input  logic        is_pixel,
	input  logic [31:0] token,
	input  logic        stream_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status
);
	import srt_pkg::*;

	srt_cmd_t cmd;
	srt_sts_t sts;

	srt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	srt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.handle       (handle),
		.is_pixel     (is_pixel),
		.token        (token),
		.stream_start (stream_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule
